// File: rtl/itr_pkg.sv
package itr_pkg;

    // Sizes
    localparam int MAX_DIGITS = 32;
    localparam int VALUE_BITS = 31;
    localparam int DIGIT_BITS = 6;
    localparam int CHAR_BITS  = 8;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DIV_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int PC_W       = 4;

    // Radix limits and character constants
    localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = DIGIT_BITS'(2);
    localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = DIGIT_BITS'(36);
    localparam logic [DIGIT_BITS-1:0] RADIX_RESET = DIGIT_BITS'(16);
    localparam logic [DIGIT_BITS-1:0] DEC_LIMIT   = DIGIT_BITS'(10);
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0]  CHAR_A      = CHAR_BITS'(8'h41);

    // Microcode fields
    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN_VALID,
        WT_DIV_DONE,
        WT_OUT_FREE
    } t_wait;

    typedef enum logic [2:0] {
        BR_NEVER,
        BR_ALWAYS,
        BR_CNT_FULL,
        BR_WORK_NZ,
        BR_CNT_NZ
    } t_branch;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_START,
        ACT_PUSH,
        ACT_POP,
        ACT_EMIT,
        ACT_EMIT_OVF
    } t_action;

    typedef struct packed {
        t_wait            wt;
        t_action          act;
        t_branch          br;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Program step addresses
    localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHECK  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_DIVGO  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DIVWT  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_TESTQ  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_POP    = PC_W'(5);
    localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_RETURN = PC_W'(7);
    localparam logic [PC_W-1:0] PC_OVF    = PC_W'(8);

    // Control from sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_start;
        logic push;
        logic pop;
        logic emit;
        logic emit_ovf;
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic out_free;
        logic cnt_full;
        logic work_nz;
        logic cnt_nz;
    } t_stat;

    // Control store
    function automatic t_uword uc_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{wt: WT_NONE, act: ACT_NONE, br: BR_ALWAYS, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:   w = '{wt: WT_IN_VALID, act: ACT_LOAD,      br: BR_NEVER,    target: PC_IDLE};
            PC_CHECK:  w = '{wt: WT_NONE,     act: ACT_NONE,      br: BR_CNT_FULL, target: PC_OVF};
            PC_DIVGO:  w = '{wt: WT_NONE,     act: ACT_DIV_START, br: BR_NEVER,    target: PC_IDLE};
            PC_DIVWT:  w = '{wt: WT_DIV_DONE, act: ACT_PUSH,      br: BR_NEVER,    target: PC_IDLE};
            PC_TESTQ:  w = '{wt: WT_NONE,     act: ACT_NONE,      br: BR_WORK_NZ,  target: PC_CHECK};
            PC_POP:    w = '{wt: WT_NONE,     act: ACT_POP,       br: BR_NEVER,    target: PC_IDLE};
            PC_EMIT:   w = '{wt: WT_OUT_FREE, act: ACT_EMIT,      br: BR_CNT_NZ,   target: PC_POP};
            PC_RETURN: w = '{wt: WT_NONE,     act: ACT_NONE,      br: BR_ALWAYS,   target: PC_IDLE};
            PC_OVF:    w = '{wt: WT_OUT_FREE, act: ACT_EMIT_OVF,  br: BR_ALWAYS,   target: PC_IDLE};
            default:   w = '{wt: WT_NONE,     act: ACT_NONE,      br: BR_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

    // Clamp a written radix into the supported range
    function automatic logic [DIGIT_BITS-1:0] eff_radix(input logic [DIGIT_BITS-1:0] r);
        logic [DIGIT_BITS-1:0] e;
        e = r;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end
        return e;
    endfunction

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d >= DEC_LIMIT) begin
            c = CHAR_BITS'(d - DEC_LIMIT) + CHAR_A;
        end else begin
            c = CHAR_BITS'(d) + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// File: rtl/itr_divider.sv
module itr_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [itr_pkg::VALUE_BITS-1:0]    i_dividend,
    input  logic [itr_pkg::DIGIT_BITS-1:0]    i_divisor,
    output logic                              o_done,
    output logic [itr_pkg::VALUE_BITS-1:0]    o_quot,
    output logic [itr_pkg::DIGIT_BITS-1:0]    o_rem
);
    import itr_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [VALUE_BITS-1:0] r_quot;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [DIGIT_BITS-1:0] r_div;

    logic [DIGIT_BITS:0]   trial;
    logic                  fits;
    logic [DIGIT_BITS:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quot[VALUE_BITS-1]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    // Control: count one quotient bit per cycle, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the right as dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[VALUE_BITS-2:0], fits};
            r_rem  <= fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: rtl/itr_sequencer.sv
module itr_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itr_pkg::t_stat i_stat,
    output itr_pkg::t_ctrl o_ctrl
);
    import itr_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            go;
    logic            taken;

    // Fetch and decode the current control word
    always_comb begin
        uw = uc_word(r_pc);

        unique case (uw.wt)
            WT_NONE:     go = 1'b1;
            WT_IN_VALID: go = i_stat.in_valid;
            WT_DIV_DONE: go = i_stat.div_done;
            WT_OUT_FREE: go = i_stat.out_free;
            default:     go = 1'b0;
        endcase

        unique case (uw.br)
            BR_NEVER:    taken = 1'b0;
            BR_ALWAYS:   taken = 1'b1;
            BR_CNT_FULL: taken = i_stat.cnt_full;
            BR_WORK_NZ:  taken = i_stat.work_nz;
            BR_CNT_NZ:   taken = i_stat.cnt_nz;
            default:     taken = 1'b1;
        endcase

        o_ctrl           = '0;
        o_ctrl.in_ready  = (uw.wt == WT_IN_VALID);
        o_ctrl.load      = go && (uw.act == ACT_LOAD);
        o_ctrl.div_start = go && (uw.act == ACT_DIV_START);
        o_ctrl.push      = go && (uw.act == ACT_PUSH);
        o_ctrl.pop       = go && (uw.act == ACT_POP);
        o_ctrl.emit      = go && (uw.act == ACT_EMIT);
        o_ctrl.emit_ovf  = go && (uw.act == ACT_EMIT_OVF);

        // Hold on a pending wait, otherwise branch or fall through
        if (!go) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: rtl/integer_to_radix_digits.sv
// Channel   Direction  Handshake                        Payload
// value     in         i_value_valid / o_value_ready    i_value
// digit     out        o_digit_valid / i_digit_ready    o_digit_char, o_last, o_overflow
// radix     in (cfg)   i_radix_valid / o_radix_ready    i_radix
//
// Each digit comes from the shared restoring divider in its one-bit-per-cycle loop, and each
// character is then popped from the digit stack and emitted into the output register.
// A new value is taken only once the previous number's last character is registered.
// A stalled digit channel holds the sequencer at the emit or overflow step; reset clears the
// program counter, the digit count and the output valid, and sets the radix to 16.
module integer_to_radix_digits (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_value_valid,
    output logic                              o_value_ready,
    input  logic [itr_pkg::VALUE_BITS-1:0]    i_value,
    output logic                              o_digit_valid,
    input  logic                              i_digit_ready,
    output logic [itr_pkg::CHAR_BITS-1:0]     o_digit_char,
    output logic                              o_last,
    output logic                              o_overflow,
    input  logic                              i_radix_valid,
    output logic                              o_radix_ready,
    input  logic [itr_pkg::DIGIT_BITS-1:0]    i_radix
);
    import itr_pkg::*;

    t_ctrl                 ctrl;
    t_stat                 stat;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIGIT_BITS-1:0] div_rem;

    logic [DIGIT_BITS-1:0] r_radix;
    logic [VALUE_BITS-1:0] r_work;
    logic [CNT_W-1:0]      r_count;
    logic [DIGIT_BITS-1:0] r_rd;
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_char;
    logic                  r_last;
    logic                  r_ovf;
    logic [CNT_W-1:0]      pop_cnt;

    logic [DIGIT_BITS-1:0] mem_stack [MAX_DIGITS];

    itr_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    itr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (r_work),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Status back to the sequencer
    always_comb begin
        pop_cnt       = r_count - CNT_W'(1);
        stat.in_valid = i_value_valid;
        stat.div_done = div_done;
        stat.out_free = !r_out_valid || i_digit_ready;
        stat.cnt_full = (r_count == CNT_W'(MAX_DIGITS));
        stat.work_nz  = (r_work != '0);
        stat.cnt_nz   = (r_count != '0);
    end

    // Radix register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_radix_valid) begin
            r_radix <= eff_radix(i_radix);
        end
    end

    // Running quotient and digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_count <= '0;
        end else begin
            if (ctrl.load) begin
                r_work  <= i_value;
                r_count <= '0;
            end else if (ctrl.push) begin
                r_work  <= div_quot;
                r_count <= r_count + CNT_W'(1);
            end else if (ctrl.pop) begin
                r_count <= pop_cnt;
            end else if (ctrl.emit_ovf) begin
                r_count <= '0;
            end
        end
    end

    // Digit stack: push at the count, registered read on pop
    always_ff @(posedge i_clk) begin
        if (ctrl.push) begin
            mem_stack[r_count[ADDR_W-1:0]] <= div_rem;
        end
        if (ctrl.pop) begin
            r_rd <= mem_stack[pop_cnt[ADDR_W-1:0]];
        end
    end

    // Output register: load a character or the overflow marker, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit || ctrl.emit_ovf) begin
            r_out_valid <= 1'b1;
        end else if (i_digit_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_char <= digit_char(r_rd);
            r_last <= (r_count == '0);
            r_ovf  <= 1'b0;
        end else if (ctrl.emit_ovf) begin
            r_char <= '0;
            r_last <= 1'b1;
            r_ovf  <= 1'b1;
        end
    end

    assign o_value_ready = ctrl.in_ready;
    assign o_radix_ready = 1'b1;
    assign o_digit_valid = r_out_valid;
    assign o_digit_char  = r_char;
    assign o_last        = r_last;
    assign o_overflow    = r_ovf;

endmodule

// File: dv/integer_to_radix_digits_tb.sv
module integer_to_radix_digits_tb;

    import itr_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int CFG_SETTLE   = 16;
    localparam int END_WAIT     = 1200;
    localparam int LONG_HOLD    = 3000;
    localparam int RANDOM_ITEMS = 340;
    localparam int FINAL_ITEMS  = 40;
    localparam int LIMIT_CYCLES = 4_000_000;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0]  ASCII_UPPER_A = 8'h41;
    localparam int                    DECIMAL_DIGITS = 10;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
        logic                 ovf;
    } t_digit_result;

    // Digit predictor and checker for the character stream
    class digit_scoreboard;
        t_digit_result         pending_digits[$];
        logic [DIGIT_BITS-1:0] radix;
        int                    errors;
        int                    values_seen;
        int                    digits_checked;
        int                    overflows;

        function new();
            radix          = RADIX_RESET;
            errors         = 0;
            values_seen    = 0;
            digits_checked = 0;
            overflows      = 0;
        endfunction

        // Clamp a raw register value to the base actually used
        function int base_of(logic [DIGIT_BITS-1:0] r);
            if (r < RADIX_MIN) begin
                return int'(RADIX_MIN);
            end
            if (r > RADIX_MAX) begin
                return int'(RADIX_MAX);
            end
            return int'(r);
        endfunction

        function void set_radix(logic [DIGIT_BITS-1:0] r);
            radix = r;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        function void fail(string msg);
            errors++;
            $error("%s", msg);
        endfunction

        // Split an accepted value into digits, most significant first
        function void note_value(logic [VALUE_BITS-1:0] value);
            logic [DIGIT_BITS-1:0]  stack [MAX_DIGITS];
            longint unsigned        quot;
            longint unsigned        base;
            int                     depth;
            t_digit_result          res;
            base  = longint'(base_of(radix));
            quot  = longint'(value);
            depth = 0;
            values_seen++;
            do begin
                if (depth >= MAX_DIGITS) begin
                    res = '{ch: '0, last: 1'b1, ovf: 1'b1};
                    pending_digits.push_back(res);
                    return;
                end
                stack[depth] = DIGIT_BITS'(quot % base);
                depth++;
                quot = quot / base;
            end while (quot != 0);
            while (depth > 0) begin
                depth--;
                if (int'(stack[depth]) < DECIMAL_DIGITS) begin
                    res.ch = ASCII_ZERO + CHAR_BITS'(stack[depth]);
                end else begin
                    res.ch = ASCII_UPPER_A + CHAR_BITS'(int'(stack[depth]) - DECIMAL_DIGITS);
                end
                res.last = (depth == 0);
                res.ovf  = 1'b0;
                pending_digits.push_back(res);
            end
        endfunction

        // Compare one digit transfer with the oldest prediction
        function void check_digit(logic [CHAR_BITS-1:0] ch, logic last, logic ovf);
            t_digit_result want;
            if (pending_digits.size() == 0) begin
                fail($sformatf("unexpected digit transfer: char 'h%h last %b overflow %b",
                               ch, last, ovf));
                return;
            end
            want = pending_digits.pop_front();
            digits_checked++;
            if (want.ovf) begin
                overflows++;
            end
            if (ch !== want.ch) begin
                fail($sformatf("digit_char: expected 'h%h, got 'h%h", want.ch, ch));
            end
            if (last !== want.last) begin
                fail($sformatf("last: expected %b, got %b", want.last, last));
            end
            if (ovf !== want.ovf) begin
                fail($sformatf("overflow: expected %b, got %b", want.ovf, ovf));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_value_valid;
    logic                  o_value_ready;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_digit_valid;
    logic                  i_digit_ready;
    logic [CHAR_BITS-1:0]  o_digit_char;
    logic                  o_last;
    logic                  o_overflow;
    logic                  i_radix_valid;
    logic                  o_radix_ready;
    logic [DIGIT_BITS-1:0] i_radix;

    digit_scoreboard       sb;
    bit                    src_gaps   = 1'b1;
    bit                    sink_gaps  = 1'b1;
    bit                    hold_req   = 1'b0;
    logic [DIGIT_BITS-1:0] cur_radix  = RADIX_RESET;
    int                    radix_writes = 0;

    integer_to_radix_digits u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .i_value       (i_value),
        .o_digit_valid (o_digit_valid),
        .i_digit_ready (i_digit_ready),
        .o_digit_char  (o_digit_char),
        .o_last        (o_last),
        .o_overflow    (o_overflow),
        .i_radix_valid (i_radix_valid),
        .o_radix_ready (o_radix_ready),
        .i_radix       (i_radix)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        sb = new();
    end

    // Watch every transfer on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_radix_valid && o_radix_ready) begin
                sb.set_radix(i_radix);
            end
            if (i_value_valid && o_value_ready) begin
                sb.note_value(i_value);
            end
            if (o_digit_valid && i_digit_ready) begin
                sb.check_digit(o_digit_char, o_last, o_overflow);
            end
        end
    end

    // Drive digit ready: random stall bursts plus one long hold on request
    initial begin : digit_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_digit_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_digit_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_digit_ready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                i_digit_ready <= 1'b0;
            end else begin
                i_digit_ready <= 1'b1;
            end
        end
    end

    // Offer one value and hold it until the transfer
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_value_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_value_valid <= 1'b1;
        i_value       <= v;
        do @(posedge i_clk); while (!o_value_ready);
    endtask

    // Drop value valid and wait until every predicted digit has come out
    task automatic drain_digits(input int settle);
        i_value_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write the radix register once the block is idle
    task automatic write_radix(input logic [DIGIT_BITS-1:0] r);
        drain_digits(CFG_SETTLE);
        i_radix_valid <= 1'b1;
        i_radix       <= r;
        do @(posedge i_clk); while (!o_radix_ready);
        i_radix_valid <= 1'b0;
        cur_radix = r;
        radix_writes++;
    endtask

    function automatic logic [DIGIT_BITS-1:0] pick_radix();
        case ($urandom_range(0, 7))
            0:       return DIGIT_BITS'($urandom_range(0, 63));
            1:       return RADIX_MIN;
            2:       return RADIX_MAX;
            default: return DIGIT_BITS'($urandom_range(2, 36));
        endcase
    endfunction

    // Mix full-width, narrow, digit-boundary and extreme values
    function automatic logic [VALUE_BITS-1:0] pick_value(input logic [DIGIT_BITS-1:0] r);
        longint unsigned p;
        longint unsigned base;
        int              k;
        base = longint'(sb.base_of(r));
        case ($urandom_range(0, 5))
            0, 1: return VALUE_BITS'($urandom);
            2:    return VALUE_BITS'($urandom >> $urandom_range(1, 31));
            3:    return VALUE_BITS'($urandom_range(0, 1000));
            4: begin
                p = 1;
                k = $urandom_range(1, VALUE_BITS);
                repeat (k) begin
                    if (p * base <= longint'(VALUE_MAX)) begin
                        p = p * base;
                    end
                end
                return VALUE_BITS'(p - $urandom_range(0, 1));
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return VALUE_BITS'(1);
                    default: return VALUE_MAX;
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        int phase_len;
        int sent;
        int phase_no;
        i_rst_n       <= 1'b0;
        i_value_valid <= 1'b0;
        i_value       <= '0;
        i_radix_valid <= 1'b0;
        i_radix       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset radix of sixteen: zero, single digit, carries, full width
        send_value('0);
        send_value(VALUE_BITS'(1));
        send_value(VALUE_BITS'(15));
        send_value(VALUE_BITS'(16));
        send_value(VALUE_MAX);
        send_value(VALUE_BITS'(32'h4000_0000));

        // Binary gives the longest digit strings
        write_radix(RADIX_MIN);
        send_value(VALUE_MAX);
        send_value(VALUE_BITS'(1));
        send_value(VALUE_BITS'(32'h5555_5555));

        // Radix below two behaves as binary
        write_radix(DIGIT_BITS'(0));
        send_value(VALUE_MAX);
        send_value(VALUE_BITS'(2));
        write_radix(DIGIT_BITS'(1));
        send_value(VALUE_BITS'(5));

        // Top radix, then radices above it that clamp to it
        write_radix(RADIX_MAX);
        send_value(VALUE_BITS'(35));
        send_value(VALUE_BITS'(36));
        send_value(VALUE_MAX);
        write_radix(DIGIT_BITS'(37));
        send_value(VALUE_BITS'(35));
        send_value(VALUE_MAX);
        write_radix(DIGIT_BITS'(63));
        send_value(VALUE_BITS'(1295));

        // Decimal boundary between digits and letters
        write_radix(DIGIT_BITS'(10));
        send_value(VALUE_BITS'(9));
        send_value(VALUE_BITS'(10));
        send_value(VALUE_MAX);
        send_value(VALUE_BITS'(1_000_000_000));

        // Random phases, each with its own radix and idling mix
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS - FINAL_ITEMS) begin
            write_radix(pick_radix());
            phase_len = $urandom_range(20, 45);
            src_gaps  = ($urandom_range(0, 2) != 0);
            sink_gaps = ($urandom_range(0, 2) != 0);
            if (phase_no == 2) begin
                hold_req = 1'b1;
            end
            repeat (phase_len) send_value(pick_value(cur_radix));
            sent += phase_len;
            phase_no++;
        end

        // Last stretch at full rate
        write_radix(pick_radix());
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (FINAL_ITEMS) send_value(pick_value(cur_radix));

        drain_digits(END_WAIT);
        $display("Converted %0d values into %0d characters (%0d overflow) over %0d radix writes.",
                 sb.values_seen, sb.digits_checked, sb.overflows, radix_writes);
        $display("Idle bursts on both channels and one %0d-cycle digit-side hold were applied.",
                 LONG_HOLD);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

endmodule
